// File: sv/sparse_term_frequency_encoder_defines.svh
// assertion macros for the term frequency encoder
`ifndef SPARSE_TERM_FREQUENCY_ENCODER_DEFINES_SVH
`define SPARSE_TERM_FREQUENCY_ENCODER_DEFINES_SVH

// same-cycle implication, checked out of reset
`define STFE_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define STFE_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/stfe_pkg.sv
`default_nettype none
package stfe_pkg;

    localparam int TERM_W    = 12;  // term index field
    localparam int NUM_W     = 13;  // term number field
    localparam int OUT_CNT_W = 16;  // term count field
    localparam int DIST_W    = 7;   // distinct total field
    localparam int IDX_EXT_W = 17;  // wide enough for vocabulary sizes below 2**17
    localparam int CNT_EXT_W = 32;  // wide enough for count widths up to 32 bits

    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 40;
    localparam int M_TUSER_W = 2;

    // m_tuser bit positions
    localparam int TU_EMPTY = 0;
    localparam int TU_OVF   = 1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_RUN,
        ST_ISSUE,
        ST_LOOKUP,
        ST_EMIT,
        ST_EMPTY
    } state_t;

    // status of the update stage toward the sequencer
    typedef struct packed {
        logic busy;
        logic eod;
        logic cnt_we;
        logic list_we;
    } upd_stat_t;

endpackage
`default_nettype wire

// File: sv/stfe_ram.sv
`default_nettype none
module stfe_ram #(
    parameter int DEPTH = 4096,
    parameter int WIDTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [2**AW];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // read data holds while re is low
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

// File: sv/stfe_update.sv
`default_nettype none
module stfe_update
    import stfe_pkg::*;
#(
    parameter int MAX_DISTINCT = 64,
    parameter int COUNT_BITS   = 16,
    parameter int AW           = 12,
    parameter int LAW          = (MAX_DISTINCT > 1) ? $clog2(MAX_DISTINCT) : 1,
    parameter int LW           = $clog2(MAX_DISTINCT + 1)
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  take,
    input  wire logic                  in_ok,
    input  wire logic                  in_eod,
    input  wire logic [AW-1:0]         in_addr,
    input  wire logic [TERM_W-1:0]     in_term,
    input  wire logic [COUNT_BITS-1:0] rdata,
    input  wire logic                  doc_done,
    output upd_stat_t                  stat,
    output logic      [AW-1:0]         wr_addr,
    output logic      [COUNT_BITS-1:0] wr_data,
    output logic      [LAW-1:0]        list_addr,
    output logic      [TERM_W-1:0]     list_data,
    output logic      [LW-1:0]         len,
    output logic                       overflow
);

    localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [LW-1:0]         LEN_MAX = LW'(MAX_DISTINCT);

    logic                  s1_valid_reg, s1_valid_next;
    logic                  s1_ok_reg;
    logic                  s1_eod_reg;
    logic [AW-1:0]         s1_addr_reg;
    logic [TERM_W-1:0]     s1_term_reg;
    logic                  fwd_hit_reg, fwd_hit_next;
    logic [COUNT_BITS-1:0] fwd_val_reg;
    logic [LW-1:0]         len_reg, len_next;
    logic                  ovf_reg, ovf_next;

    logic [COUNT_BITS-1:0] cur;
    logic                  act;
    logic                  cnt_we;
    logic                  list_we;

    // the count just written back is not yet visible in the memory read
    assign cur = fwd_hit_reg ? fwd_val_reg : rdata;
    assign act = s1_valid_reg && s1_ok_reg;

    always_comb begin
        cnt_we   = 1'b0;
        list_we  = 1'b0;
        wr_data  = cur + COUNT_BITS'(1);
        len_next = len_reg;
        ovf_next = ovf_reg;
        if (act) begin
            if (cur != '0) begin
                cnt_we = (cur != CNT_MAX);
            end else if (len_reg < LEN_MAX) begin
                cnt_we   = 1'b1;
                list_we  = 1'b1;
                wr_data  = COUNT_BITS'(1);
                len_next = len_reg + LW'(1);
            end else begin
                ovf_next = 1'b1;
            end
        end
        if (doc_done) begin
            len_next = '0;
            ovf_next = 1'b0;
        end
        s1_valid_next = take;
        fwd_hit_next  = cnt_we && (s1_addr_reg == in_addr);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            fwd_hit_reg  <= 1'b0;
            len_reg      <= '0;
            ovf_reg      <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            fwd_hit_reg  <= fwd_hit_next;
            len_reg      <= len_next;
            ovf_reg      <= ovf_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            s1_ok_reg   <= in_ok;
            s1_eod_reg  <= in_eod;
            s1_addr_reg <= in_addr;
            s1_term_reg <= in_term;
            fwd_val_reg <= wr_data;
        end
    end

    assign stat.busy    = s1_valid_reg;
    assign stat.eod     = s1_valid_reg && s1_eod_reg;
    assign stat.cnt_we  = cnt_we;
    assign stat.list_we = list_we;

    assign wr_addr   = s1_addr_reg;
    assign list_addr = len_reg[LAW-1:0];
    assign list_data = s1_term_reg;
    assign len       = len_reg;
    assign overflow  = ovf_reg;

endmodule
`default_nettype wire

// File: sv/sparse_term_frequency_encoder.sv
// sparse term frequency encoder: counts vocabulary terms per document and, when
// a transfer with s_tlast closes the document, sends one result per distinct term
// in the order the terms first appeared (term index plus one, count, distinct
// total, overflow flag), m_tlast on the last one; an empty document gives one
// result with m_tuser doc_empty set. term items are taken one per cycle while
// s_tready is high: the per-term counts sit in one memory with a registered read,
// and a count written back is forwarded to an item for the same term that follows
// right behind. after the closing transfer the block finishes its update, then
// reads the first list entry; each result then takes a count lookup, then output
// and clear of that count, as the count memory has one read and one write port.
// an empty document's result skips the lookup. a stalled m_tready holds the drain
// at its output step. no input is taken while a document is sent; s_tready returns
// in the cycle the last result is presented. after reset the count memory is
// zeroed entry by entry, with s_tready low. terms at or beyond VOCAB_SIZE and
// transfers with s_tuser low count nothing; distinct terms past MAX_DISTINCT are
// dropped and flagged. counts saturate at COUNT_BITS bits and m_tdata carries
// their low 16 bits.
`default_nettype none
`include "sparse_term_frequency_encoder_defines.svh"
module sparse_term_frequency_encoder
    import stfe_pkg::*;
#(
    parameter int VOCAB_SIZE   = 4096,
    parameter int MAX_DISTINCT = 64,
    parameter int COUNT_BITS   = 16
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // input stream
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,   // [11:0] term_index, rest zero
    input  wire logic                 s_tuser,   // [0] term_valid
    input  wire logic                 s_tlast,   // end_of_doc
    // result stream
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic      [M_TDATA_W-1:0] m_tdata,   // [12:0] term_number,
                                                 // [28:13] term_count,
                                                 // [35:29] distinct_terms, rest zero
    output logic      [M_TUSER_W-1:0] m_tuser,   // [0] doc_empty, [1] list_overflow
    output logic                      m_tlast    // last_of_doc
);

    localparam int AW  = (VOCAB_SIZE > 1) ? $clog2(VOCAB_SIZE) : 1;
    localparam int LAW = (MAX_DISTINCT > 1) ? $clog2(MAX_DISTINCT) : 1;
    localparam int LW  = $clog2(MAX_DISTINCT + 1);
    localparam logic [IDX_EXT_W-1:0] VOCAB_LIM = IDX_EXT_W'(VOCAB_SIZE);
    localparam logic [AW-1:0]        CLR_LAST  = AW'(VOCAB_SIZE - 1);

    // sequencer
    state_t state_reg, state_next;
    logic [AW-1:0] clr_addr_reg, clr_addr_next;   // reset clearing pass
    logic [LW-1:0] j_reg, j_next;                 // drain position in the list
    logic [TERM_W-1:0] term_reg;                  // term being sent

    // output register
    logic                 m_valid_reg, m_valid_next;
    logic [M_TDATA_W-1:0] m_data_reg, m_data_next;
    logic [M_TUSER_W-1:0] m_user_reg, m_user_next;
    logic                 m_last_reg, m_last_next;
    logic                 out_free;

    // input side
    logic                 take;
    logic [IDX_EXT_W-1:0] in_ext;
    logic                 in_ok;

    // update stage
    upd_stat_t             ustat;
    logic [AW-1:0]         upd_waddr;
    logic [COUNT_BITS-1:0] upd_wdata;
    logic [LAW-1:0]        upd_laddr;
    logic [TERM_W-1:0]     upd_ldata;
    logic [LW-1:0]         len;
    logic                  overflow;
    logic                  doc_done;

    // count memory ports
    logic                  cnt_we, cnt_re;
    logic [AW-1:0]         cnt_waddr, cnt_raddr;
    logic [COUNT_BITS-1:0] cnt_wdata, cnt_rdata;

    // list memory ports
    logic                  list_re;
    logic [LAW-1:0]        list_raddr;
    logic [TERM_W-1:0]     list_rdata;

    logic [IDX_EXT_W-1:0]  list_ext;
    logic [IDX_EXT_W-1:0]  term_ext;
    logic [CNT_EXT_W-1:0]  cnt_ext;
    logic                  emit_last;

    // a term past the vocabulary is skipped like an unknown word
    assign in_ext   = IDX_EXT_W'(s_tdata[TERM_W-1:0]);
    assign in_ok    = s_tuser && (in_ext < VOCAB_LIM);
    assign s_tready = (state_reg == ST_RUN) && !ustat.eod;
    assign take     = s_tvalid && s_tready;

    assign list_ext  = IDX_EXT_W'(list_rdata);
    assign term_ext  = IDX_EXT_W'(term_reg);
    assign cnt_ext   = CNT_EXT_W'(cnt_rdata);
    assign out_free  = !m_valid_reg || m_tready;
    assign emit_last = (LW'(j_reg + LW'(1)) == len);

    stfe_ram #(
        .DEPTH (VOCAB_SIZE),
        .WIDTH (COUNT_BITS),
        .AW    (AW)
    ) u_count_ram (
        .aclk  (aclk),
        .we    (cnt_we),
        .waddr (cnt_waddr),
        .wdata (cnt_wdata),
        .re    (cnt_re),
        .raddr (cnt_raddr),
        .rdata (cnt_rdata)
    );

    stfe_ram #(
        .DEPTH (MAX_DISTINCT),
        .WIDTH (TERM_W),
        .AW    (LAW)
    ) u_list_ram (
        .aclk  (aclk),
        .we    (ustat.list_we),
        .waddr (upd_laddr),
        .wdata (upd_ldata),
        .re    (list_re),
        .raddr (list_raddr),
        .rdata (list_rdata)
    );

    stfe_update #(
        .MAX_DISTINCT (MAX_DISTINCT),
        .COUNT_BITS   (COUNT_BITS),
        .AW           (AW),
        .LAW          (LAW),
        .LW           (LW)
    ) u_update (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .take      (take),
        .in_ok     (in_ok),
        .in_eod    (s_tlast),
        .in_addr   (in_ext[AW-1:0]),
        .in_term   (s_tdata[TERM_W-1:0]),
        .rdata     (cnt_rdata),
        .doc_done  (doc_done),
        .stat      (ustat),
        .wr_addr   (upd_waddr),
        .wr_data   (upd_wdata),
        .list_addr (upd_laddr),
        .list_data (upd_ldata),
        .len       (len),
        .overflow  (overflow)
    );

    always_comb begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        j_next        = j_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_data_next   = m_data_reg;
        m_user_next   = m_user_reg;
        m_last_next   = m_last_reg;
        doc_done      = 1'b0;

        // count memory: term updates by default
        cnt_we    = ustat.cnt_we;
        cnt_waddr = upd_waddr;
        cnt_wdata = upd_wdata;
        cnt_re    = take;
        cnt_raddr = in_ext[AW-1:0];

        list_re    = 1'b0;
        list_raddr = j_reg[LAW-1:0];

        case (state_reg)
            ST_CLEAR: begin
                cnt_we        = 1'b1;
                cnt_waddr     = clr_addr_reg;
                cnt_wdata     = '0;
                clr_addr_next = clr_addr_reg + AW'(1);
                if (clr_addr_reg == CLR_LAST) begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                // the closing item finishes its update in this cycle
                if (ustat.eod) begin
                    state_next = ST_ISSUE;
                end
            end
            ST_ISSUE: begin
                j_next     = '0;
                list_re    = 1'b1;
                list_raddr = '0;
                state_next = (len == '0) ? ST_EMPTY : ST_LOOKUP;
            end
            ST_LOOKUP: begin
                // read the count and fetch the next list entry behind it
                cnt_re     = 1'b1;
                cnt_raddr  = list_ext[AW-1:0];
                list_re    = 1'b1;
                list_raddr = LAW'(j_reg + LW'(1));
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = M_TDATA_W'({DIST_W'(len), cnt_ext[OUT_CNT_W-1:0],
                                               NUM_W'(term_reg) + NUM_W'(1)});
                    m_user_next  = '0;
                    m_user_next[TU_OVF] = overflow;
                    m_last_next  = emit_last;
                    cnt_we       = 1'b1;
                    cnt_waddr    = term_ext[AW-1:0];
                    cnt_wdata    = '0;
                    j_next       = j_reg + LW'(1);
                    if (emit_last) begin
                        doc_done   = 1'b1;
                        state_next = ST_RUN;
                    end else begin
                        state_next = ST_LOOKUP;
                    end
                end
            end
            ST_EMPTY: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = '0;
                    m_user_next  = '0;
                    m_user_next[TU_EMPTY] = 1'b1;
                    m_user_next[TU_OVF]   = overflow;
                    m_last_next  = 1'b1;
                    doc_done     = 1'b1;
                    state_next   = ST_RUN;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_addr_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        j_reg      <= j_next;
        m_data_reg <= m_data_next;
        m_user_reg <= m_user_next;
        m_last_reg <= m_last_next;
        if (state_reg == ST_LOOKUP) begin
            term_reg <= list_rdata;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;
    assign m_tlast  = m_last_reg;

    // checks
    `STFE_ASSERT_NOW(a_len_bound, aclk, aresetn, 1'b1, len <= LW'(MAX_DISTINCT), "list length past depth")
    `STFE_ASSERT_NOW(a_listed_nonzero, aclk, aresetn, state_reg == ST_EMIT, cnt_rdata != '0, "listed term read with zero count")
    `STFE_ASSERT_NEXT(a_close_stalls, aclk, aresetn, ustat.eod, !s_tready, "input taken while a document closes")
    `STFE_ASSERT_NOW(a_empty_shape, aclk, aresetn, m_valid_reg && m_user_reg[TU_EMPTY], m_last_reg && (m_data_reg == '0), "malformed empty document result")

endmodule
`default_nettype wire
